// File: sv/video_master_clock_scheduler_top_macros.svh
// Assertion macros shared by the master clock scheduler RTL.
// Needs a clk and an active-low rst_n in the scope where a macro is used.
`ifndef VIDEO_MASTER_CLOCK_SCHEDULER_TOP_MACROS_SVH
`define VIDEO_MASTER_CLOCK_SCHEDULER_TOP_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define VMCS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define VMCS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/vmcs_pkg.sv
// Package for the video master clock scheduler: widths, request and register codes,
// the configuration and result types, and the beam formula constants. No dependencies.
package vmcs_pkg;

    localparam int LINE_W     = 12;
    localparam int LINE_INC_W = LINE_W + 1;
    localparam int SCAN_W     = 9;
    localparam int DIV_W      = 8;
    localparam int CNT_W      = 32;
    localparam int BEAM_W     = 8;
    localparam int CYC_W      = 8;
    localparam int REQ_W      = 2;
    localparam int SEL_W      = 2;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 12;

    // Request kinds carried on the input tuser.
    localparam logic [REQ_W-1:0] REQ_TICK       = 2'd0;
    localparam logic [REQ_W-1:0] REQ_CPU_DONE   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_VIDEO_DONE = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_W-1:0] CFG_VIDEO_MODE   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_LINE_LENGTH  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_LINE_STEP    = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_FRAME_EDGE   = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_VIDEO_DIV    = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_CPU_DIV      = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] CFG_VBLANK_FIRST = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] CFG_VBLANK_LAST  = 3'd7;

    // Beam formula: positions past this point gain half a pixel in NTSC and PAL alike; PAL scales by 2/5.
    localparam logic [LINE_INC_W-1:0] NTSC_STEP_REF = 13'd412;
    localparam logic [1:0]            PAL_OFFSET    = 2'd2;
    // ceil(2^16 / 5); exact for every numerator below 2^14.
    localparam logic [13:0]           PAL_RECIP     = 14'd13108;

    typedef struct packed {
        logic              video_mode;
        logic [LINE_W-1:0] line_length;
        logic [LINE_W-1:0] line_step_tick;
        logic [LINE_W-1:0] frame_edge_tick;
        logic [DIV_W-1:0]  video_divisor;
        logic [DIV_W-1:0]  cpu_divisor;
        logic [SCAN_W-1:0] vblank_first_line;
        logic [SCAN_W-1:0] vblank_last_line;
    } cfg_t;

    // First member sits in the top bits, so exec_select lands at bit 0.
    typedef struct packed {
        logic [CNT_W-1:0]  video_steps;
        logic [BEAM_W-1:0] beam_x;
        logic [CNT_W-1:0]  frame_number;
        logic [LINE_W-1:0] line_tick_now;
        logic [SCAN_W-1:0] scanline_number;
        logic              frame_done;
        logic              vblank_rise;
        logic              vblank_level;
        logic [SEL_W-1:0]  exec_select;
    } result_t;

    localparam int RESULT_W = $bits(result_t);
    localparam int TDATA_W  = ((RESULT_W + 7) / 8) * 8;

endpackage

// File: sv/vmcs_beam.sv
// Beam X position seen by a CPU bus read, from the line tick and the configuration.
// Depends on vmcs_pkg.
module vmcs_beam
    import vmcs_pkg::*;
(
    input  cfg_t              cfg,
    input  logic [LINE_W-1:0] line_tick,
    output logic [BEAM_W-1:0] beam_x
);

    logic [LINE_INC_W-1:0] read_tick;
    logic [LINE_INC_W-1:0] clamped;
    logic [13:0]           pal_num;
    logic [27:0]           pal_prod;
    logic [LINE_INC_W-1:0] scaled;
    logic [13:0]           x_full;

    always_comb
    begin
        // The bus read lands cpu_divisor ticks ahead of the current tick.
        read_tick = {1'b0, line_tick} + {{(LINE_INC_W-DIV_W){1'b0}}, cfg.cpu_divisor};
        if (read_tick >= {1'b0, cfg.line_length})
        begin
            if (cfg.line_length == '0)
                clamped = '0;
            else
                clamped = {1'b0, cfg.line_length - LINE_W'(1)};
        end
        else
        begin
            clamped = read_tick;
        end

        // (2t + 2) / 5 by multiplying with the reciprocal.
        pal_num  = {clamped, 1'b0} + {12'd0, PAL_OFFSET};
        pal_prod = pal_num * PAL_RECIP;

        if (cfg.video_mode)
            scaled = {1'b0, pal_prod[27:16]};
        else
            scaled = clamped;

        x_full = {1'b0, scaled} + {13'd0, (scaled > NTSC_STEP_REF)};
        beam_x = x_full[BEAM_W:1];
    end

endmodule

// File: sv/video_master_clock_scheduler_top.sv
// Top level of the video master clock scheduler: handshake, state and result register.
// Depends on vmcs_pkg, vmcs_beam and video_master_clock_scheduler_top_macros.svh.
//
//  Channel   Direction  Handshake                      Contents
//  s_axis    in         s_axis_tvalid/s_axis_tready    tuser request kind, tdata cycles
//  m_axis    out        m_axis_tvalid/m_axis_tready    tdata scheduler result
//  cfg       in         cfg_we (no wait)               register index and write data
//
// One request is taken per cycle unless a stalled output has filled both registers.
// A request is registered, then the timing state and the result are computed in a
// single pass and stored together in the result register.
// The path from m_axis_tready to s_axis_tready is combinational, so a stalled output
// stops the input register only when both stages are full.
// Reset clears the timing state, loads the configuration defaults and starts in vblank.
`include "video_master_clock_scheduler_top_macros.svh"

module video_master_clock_scheduler_top
    import vmcs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [1:0] req_type
    input  logic [REQ_W-1:0]      s_axis_tuser,
    // [7:0] instr_cycles
    input  logic [CYC_W-1:0]      s_axis_tdata,

    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [1:0] exec_select, [2] vblank_level, [3] vblank_rise, [4] frame_done,
    // [13:5] scanline_number, [25:14] line_tick_now, [57:26] frame_number,
    // [65:58] beam_x, [97:66] video_steps, [103:98] zero
    output logic [TDATA_W-1:0]    m_axis_tdata,

    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    // Configuration.
    cfg_t cfg_reg;

    // Input register.
    logic             in_valid_reg;
    logic [REQ_W-1:0] in_req_reg;
    logic [CYC_W-1:0] in_cyc_reg;

    // Timing state.
    logic [LINE_W-1:0] line_tick_reg,   line_tick_next;
    logic [SCAN_W-1:0] scanline_reg,    scanline_next;
    logic [CNT_W-1:0]  frame_count_reg, frame_count_next;
    logic              vblank_reg,      vblank_next;
    logic [DIV_W-1:0]  video_phase_reg, video_phase_next;
    logic [DIV_W-1:0]  cpu_phase_reg,   cpu_phase_next;
    logic [DIV_W-1:0]  cpu_debt_reg,    cpu_debt_next;
    logic [CNT_W-1:0]  video_steps_reg, video_steps_next;

    // Result register.
    logic    out_valid_reg;
    result_t result_reg, result_next;

    logic                  move;
    logic [LINE_INC_W-1:0] tick_inc;
    logic [SCAN_W-1:0]     scan_stepped;
    logic [DIV_W:0]        video_phase_inc;
    logic [DIV_W:0]        cpu_phase_inc;
    logic                  video_slot;
    logic                  cpu_slot;
    logic                  cpu_run;
    logic                  rise;
    logic                  done;
    logic [BEAM_W-1:0]     beam_x;

    // The registered request moves on when the result register is free or being emptied.
    assign move          = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || move;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(TDATA_W-RESULT_W){1'b0}}, result_reg};

    // Next-state logic for the request held in the input register.
    always_comb
    begin
        line_tick_next   = line_tick_reg;
        scanline_next    = scanline_reg;
        frame_count_next = frame_count_reg;
        vblank_next      = vblank_reg;
        video_phase_next = video_phase_reg;
        cpu_phase_next   = cpu_phase_reg;
        cpu_debt_next    = cpu_debt_reg;
        video_steps_next = video_steps_reg;
        rise             = 1'b0;
        done             = 1'b0;
        cpu_run          = 1'b0;
        scan_stepped     = scanline_reg;
        video_slot       = 1'b0;
        cpu_slot         = 1'b0;

        tick_inc        = {1'b0, line_tick_reg} + LINE_INC_W'(1);
        video_phase_inc = {1'b0, video_phase_reg} + (DIV_W+1)'(1);
        cpu_phase_inc   = {1'b0, cpu_phase_reg} + (DIV_W+1)'(1);

        unique case (in_req_reg)
            REQ_TICK:
            begin
                if (tick_inc == {1'b0, cfg_reg.line_step_tick})
                    scan_stepped = scanline_reg + SCAN_W'(1);
                scanline_next = scan_stepped;

                // The rise check runs before the frame end, so with equal lines
                // vblank finishes low while the rise is still reported.
                if (tick_inc == {1'b0, cfg_reg.frame_edge_tick})
                begin
                    if (scan_stepped == cfg_reg.vblank_first_line && !vblank_reg)
                    begin
                        vblank_next = 1'b1;
                        rise        = 1'b1;
                    end
                    if (scan_stepped == cfg_reg.vblank_last_line)
                    begin
                        scanline_next    = '0;
                        vblank_next      = 1'b0;
                        frame_count_next = frame_count_reg + CNT_W'(1);
                        done             = 1'b1;
                    end
                end

                if (tick_inc >= {1'b0, cfg_reg.line_length})
                    line_tick_next = '0;
                else
                    line_tick_next = tick_inc[LINE_W-1:0];

                // A phase wraps when it reaches its divisor; a zero divisor wraps always.
                video_slot = (video_phase_inc >= {1'b0, cfg_reg.video_divisor});
                cpu_slot   = (cpu_phase_inc >= {1'b0, cfg_reg.cpu_divisor});
                video_phase_next = video_slot ? '0 : video_phase_inc[DIV_W-1:0];
                cpu_phase_next   = cpu_slot ? '0 : cpu_phase_inc[DIV_W-1:0];

                // A CPU slot first pays off outstanding instruction cycles.
                if (cpu_slot)
                begin
                    if (cpu_debt_reg != '0)
                        cpu_debt_next = cpu_debt_reg - DIV_W'(1);
                    else
                        cpu_run = 1'b1;
                end
            end
            REQ_CPU_DONE:
            begin
                cpu_debt_next = in_cyc_reg - CYC_W'(1);
            end
            REQ_VIDEO_DONE:
            begin
                video_steps_next = video_steps_reg + CNT_W'(1);
            end
            default:
            begin
            end
        endcase
    end

    vmcs_beam u_beam
    (
        .cfg       (cfg_reg),
        .line_tick (line_tick_next),
        .beam_x    (beam_x)
    );

    always_comb
    begin
        result_next.exec_select     = {video_slot, cpu_run};
        result_next.vblank_level    = vblank_next;
        result_next.vblank_rise     = rise;
        result_next.frame_done      = done;
        result_next.scanline_number = scanline_next;
        result_next.line_tick_now   = line_tick_next;
        result_next.frame_number    = frame_count_next;
        result_next.beam_x          = beam_x;
        result_next.video_steps     = video_steps_next;
    end

    // Configuration registers, to be written only while the block is idle; the block itself does not enforce this.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.video_mode        <= 1'b0;
            cfg_reg.line_length       <= 12'd455;
            cfg_reg.line_step_tick    <= 12'd412;
            cfg_reg.frame_edge_tick   <= 12'd365;
            cfg_reg.video_divisor     <= 8'd1;
            cfg_reg.cpu_divisor       <= 8'd20;
            cfg_reg.vblank_first_line <= 9'd241;
            cfg_reg.vblank_last_line  <= 9'd263;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_VIDEO_MODE:   cfg_reg.video_mode        <= cfg_wdata[0];
                CFG_LINE_LENGTH:  cfg_reg.line_length       <= cfg_wdata[LINE_W-1:0];
                CFG_LINE_STEP:    cfg_reg.line_step_tick    <= cfg_wdata[LINE_W-1:0];
                CFG_FRAME_EDGE:   cfg_reg.frame_edge_tick   <= cfg_wdata[LINE_W-1:0];
                CFG_VIDEO_DIV:    cfg_reg.video_divisor     <= cfg_wdata[DIV_W-1:0];
                CFG_CPU_DIV:      cfg_reg.cpu_divisor       <= cfg_wdata[DIV_W-1:0];
                CFG_VBLANK_FIRST: cfg_reg.vblank_first_line <= cfg_wdata[SCAN_W-1:0];
                CFG_VBLANK_LAST:  cfg_reg.vblank_last_line  <= cfg_wdata[SCAN_W-1:0];
            endcase
        end
    end

    // Handshake state and timing state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            line_tick_reg   <= '0;
            scanline_reg    <= '0;
            frame_count_reg <= '0;
            vblank_reg      <= 1'b1;
            video_phase_reg <= '0;
            cpu_phase_reg   <= '0;
            cpu_debt_reg    <= '0;
            video_steps_reg <= '0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                in_valid_reg <= 1'b1;
            else if (move)
                in_valid_reg <= 1'b0;

            if (move)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;

            if (move)
            begin
                line_tick_reg   <= line_tick_next;
                scanline_reg    <= scanline_next;
                frame_count_reg <= frame_count_next;
                vblank_reg      <= vblank_next;
                video_phase_reg <= video_phase_next;
                cpu_phase_reg   <= cpu_phase_next;
                cpu_debt_reg    <= cpu_debt_next;
                video_steps_reg <= video_steps_next;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_req_reg <= s_axis_tuser;
            in_cyc_reg <= s_axis_tdata;
        end
        if (move)
            result_reg <= result_next;
    end

    // A finished frame leaves the beam on line zero outside vblank.
    `VMCS_ASSERT_NOW(a_frame_end_state, out_valid_reg && result_reg.frame_done, result_reg.scanline_number == '0 && !result_reg.vblank_level, "frame end without line reset")
    // A rise is only ever cancelled by a frame end on the same tick.
    `VMCS_ASSERT_NOW(a_rise_level, out_valid_reg && result_reg.vblank_rise, result_reg.vblank_level || result_reg.frame_done, "vblank rise lost")
    // Timing state changes only when a request moves into the result register.
    `VMCS_ASSERT_NEXT(a_state_hold, !move, $stable(frame_count_reg) && $stable(line_tick_reg) && $stable(cpu_debt_reg), "state changed without a request")
    // Both stages full and output stalled must stop the input.
    `VMCS_ASSERT_NOW(a_full_stall, in_valid_reg && out_valid_reg && !m_axis_tready, !s_axis_tready, "input taken while pipeline is full")

endmodule

// File: dv/video_master_clock_scheduler_top_tb.sv
// Self-checking testbench for the video master clock scheduler top level.
// Drives requests and register writes, predicts every result and compares it field by field.
// Depends on vmcs_pkg and video_master_clock_scheduler_top.
module video_master_clock_scheduler_top_tb;
    import vmcs_pkg::*;

    // The package has no name for the unused request code, so it is given one here.
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 8;
    localparam int PAL_MUL      = 2;
    localparam int PAL_DIV      = 5;
    localparam int PAL_ROUND    = 2;

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // [1:0] req_type
    logic [REQ_W-1:0]      s_axis_tuser  = REQ_TICK;
    // [7:0] instr_cycles
    logic [CYC_W-1:0]      s_axis_tdata  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // [1:0] exec_select, [2] vblank_level, [3] vblank_rise, [4] frame_done,
    // [13:5] scanline_number, [25:14] line_tick_now, [57:26] frame_number,
    // [65:58] beam_x, [97:66] video_steps, [103:98] zero
    logic [TDATA_W-1:0]    m_axis_tdata;
    logic                  cfg_we        = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr      = CFG_VIDEO_MODE;
    logic [CFG_DATA_W-1:0] cfg_wdata     = '0;

    // Predicted scheduler state and the settings it runs under.
    cfg_t              sched_cfg;
    logic [LINE_W-1:0] tick_in_line;
    logic [SCAN_W-1:0] cur_scanline;
    logic [CNT_W-1:0]  frames_done;
    logic              in_vblank;
    logic [DIV_W-1:0]  video_slot_phase;
    logic [DIV_W-1:0]  cpu_slot_phase;
    logic [DIV_W-1:0]  cpu_cycles_owed;
    logic [CNT_W-1:0]  video_steps_seen;

    result_t pending_results[$];
    int      mismatch_count   = 0;
    int      idle_cycles      = 0;
    int      send_gap_max     = 0;
    int      ready_stall_max  = 0;
    int      hold_off_request = 0;

    video_master_clock_scheduler_top u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    function automatic void reset_prediction();
        sched_cfg.video_mode        = 1'b0;
        sched_cfg.line_length       = 12'd455;
        sched_cfg.line_step_tick    = 12'd412;
        sched_cfg.frame_edge_tick   = 12'd365;
        sched_cfg.video_divisor     = 8'd1;
        sched_cfg.cpu_divisor       = 8'd20;
        sched_cfg.vblank_first_line = 9'd241;
        sched_cfg.vblank_last_line  = 9'd263;
        tick_in_line     = '0;
        cur_scanline     = '0;
        frames_done      = '0;
        in_vblank        = 1'b1;
        video_slot_phase = '0;
        cpu_slot_phase   = '0;
        cpu_cycles_owed  = '0;
        video_steps_seen = '0;
    endfunction

    // Horizontal position a CPU bus read would see, one CPU slot ahead of the line tick.
    function automatic logic [BEAM_W-1:0] beam_at_read();
        int unsigned pos;
        pos = tick_in_line + sched_cfg.cpu_divisor;
        if (pos >= sched_cfg.line_length)
            pos = (sched_cfg.line_length == 0) ? 0 : sched_cfg.line_length - 1;
        if (sched_cfg.video_mode)
            pos = (pos * PAL_MUL + PAL_ROUND) / PAL_DIV;
        if (pos > NTSC_STEP_REF)
            pos = pos + 1;
        return BEAM_W'(pos >> 1);
    endfunction

    // Advances a slot phase; a divisor of zero behaves like one.
    function automatic logic step_slot(inout logic [DIV_W-1:0] phase,
                                       input logic [DIV_W-1:0] divisor);
        int unsigned next_phase;
        next_phase = phase + 1;
        if (next_phase >= divisor)
            next_phase = 0;
        phase = DIV_W'(next_phase);
        return (phase == 0);
    endfunction

    function automatic result_t predict_schedule(input logic [REQ_W-1:0] kind,
                                                 input logic [CYC_W-1:0] cycles);
        result_t     res;
        int unsigned next_tick;
        logic        video_go;
        logic        cpu_slot;
        logic        cpu_go;
        res = '0;
        case (kind)
            REQ_TICK:
            begin
                next_tick = tick_in_line + 1;
                if (next_tick == sched_cfg.line_step_tick)
                    cur_scanline = cur_scanline + 1'b1;
                if (next_tick == sched_cfg.frame_edge_tick)
                begin
                    // The rise is checked before the frame end, so both can fire together.
                    if (cur_scanline == sched_cfg.vblank_first_line && !in_vblank)
                    begin
                        in_vblank       = 1'b1;
                        res.vblank_rise = 1'b1;
                    end
                    if (cur_scanline == sched_cfg.vblank_last_line)
                    begin
                        cur_scanline   = '0;
                        in_vblank      = 1'b0;
                        frames_done    = frames_done + 1'b1;
                        res.frame_done = 1'b1;
                    end
                end
                if (next_tick >= sched_cfg.line_length)
                    next_tick = 0;
                tick_in_line = LINE_W'(next_tick);
                video_go = step_slot(video_slot_phase, sched_cfg.video_divisor);
                cpu_slot = step_slot(cpu_slot_phase, sched_cfg.cpu_divisor);
                cpu_go   = 1'b0;
                if (cpu_slot)
                begin
                    if (cpu_cycles_owed != 0)
                        cpu_cycles_owed = cpu_cycles_owed - 1'b1;
                    else
                        cpu_go = 1'b1;
                end
                res.exec_select = {video_go, cpu_go};
            end
            REQ_CPU_DONE:
                cpu_cycles_owed = cycles - 1'b1;
            REQ_VIDEO_DONE:
                video_steps_seen = video_steps_seen + 1'b1;
            default:
                ;
        endcase
        res.vblank_level    = in_vblank;
        res.scanline_number = cur_scanline;
        res.line_tick_now   = tick_in_line;
        res.frame_number    = frames_done;
        res.beam_x          = beam_at_read();
        res.video_steps     = video_steps_seen;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("MISMATCH %s: got 0x%0h, expected 0x%0h at %0t", what, got, want, $time);
        mismatch_count++;
    endtask

    task automatic check_result(input result_t got, input result_t want);
        if (got.exec_select !== want.exec_select)
            report_mismatch("exec_select", 64'(got.exec_select), 64'(want.exec_select));
        if (got.vblank_level !== want.vblank_level)
            report_mismatch("vblank_level", 64'(got.vblank_level), 64'(want.vblank_level));
        if (got.vblank_rise !== want.vblank_rise)
            report_mismatch("vblank_rise", 64'(got.vblank_rise), 64'(want.vblank_rise));
        if (got.frame_done !== want.frame_done)
            report_mismatch("frame_done", 64'(got.frame_done), 64'(want.frame_done));
        if (got.scanline_number !== want.scanline_number)
            report_mismatch("scanline_number", 64'(got.scanline_number),
                            64'(want.scanline_number));
        if (got.line_tick_now !== want.line_tick_now)
            report_mismatch("line_tick_now", 64'(got.line_tick_now),
                            64'(want.line_tick_now));
        if (got.frame_number !== want.frame_number)
            report_mismatch("frame_number", 64'(got.frame_number), 64'(want.frame_number));
        if (got.beam_x !== want.beam_x)
            report_mismatch("beam_x", 64'(got.beam_x), 64'(want.beam_x));
        if (got.video_steps !== want.video_steps)
            report_mismatch("video_steps", 64'(got.video_steps), 64'(want.video_steps));
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_results.size() == 0)
                report_mismatch("result with no request outstanding",
                                m_axis_tdata[63:0], '0);
            else
                check_result(result_t'(m_axis_tdata[RESULT_W-1:0]),
                             pending_results.pop_front());
        end
    end

    // Ends the run if neither side completes a handshake for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("FAIL video_master_clock_scheduler_top");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Result side: a random stall before each result, or a long hold-off when one is asked for.
    initial
    begin : result_sink
        int stall;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_off_request > 0)
            begin
                stall            = hold_off_request;
                hold_off_request = 0;
            end
            else
                stall = $urandom_range(0, ready_stall_max);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_axis_tvalid && hold_off_request == 0);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    // Offers one request after a random gap and predicts its result once it is taken.
    task automatic send_request(input logic [REQ_W-1:0] kind, input logic [CYC_W-1:0] cycles);
        int gap;
        gap = $urandom_range(0, send_gap_max);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= cycles;
        do
            @(posedge clk);
        while (!s_axis_tready);
        pending_results.push_back(predict_schedule(kind, cycles));
    endtask

    task automatic send_ticks(input int count);
        repeat (count) send_request(REQ_TICK, CYC_W'($urandom));
    endtask

    task automatic send_random(input int count, input int tick_pct);
        logic [REQ_W-1:0] kind;
        logic [CYC_W-1:0] cycles;
        repeat (count)
        begin
            if ($urandom_range(0, 99) < tick_pct)
                kind = REQ_TICK;
            else
                case ($urandom_range(0, 6))
                    0, 1, 2: kind = REQ_CPU_DONE;
                    3, 4, 5: kind = REQ_VIDEO_DONE;
                    default: kind = REQ_UNUSED;
                endcase
            // Short instructions mostly, so the debt is paid off and the CPU runs again.
            if ($urandom_range(0, 1))
                cycles = CYC_W'($urandom_range(0, 3));
            else
                cycles = CYC_W'($urandom_range(0, 255));
            send_request(kind, cycles);
        end
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Waits for the block to empty, then writes every register, one per cycle.
    task automatic program_config(input cfg_t settings);
        logic [CFG_ADDR_W-1:0] reg_index [8];
        logic [CFG_DATA_W-1:0] reg_value [8];
        int                    reg_width [8];
        logic [CFG_DATA_W-1:0] junk;
        int                    i;
        wait_idle();
        reg_index = '{CFG_VIDEO_MODE, CFG_LINE_LENGTH, CFG_LINE_STEP, CFG_FRAME_EDGE,
                      CFG_VIDEO_DIV, CFG_CPU_DIV, CFG_VBLANK_FIRST, CFG_VBLANK_LAST};
        reg_width = '{1, LINE_W, LINE_W, LINE_W, DIV_W, DIV_W, SCAN_W, SCAN_W};
        reg_value[0] = CFG_DATA_W'(settings.video_mode);
        reg_value[1] = CFG_DATA_W'(settings.line_length);
        reg_value[2] = CFG_DATA_W'(settings.line_step_tick);
        reg_value[3] = CFG_DATA_W'(settings.frame_edge_tick);
        reg_value[4] = CFG_DATA_W'(settings.video_divisor);
        reg_value[5] = CFG_DATA_W'(settings.cpu_divisor);
        reg_value[6] = CFG_DATA_W'(settings.vblank_first_line);
        reg_value[7] = CFG_DATA_W'(settings.vblank_last_line);
        for (i = 0; i < 8; i++)
        begin
            // Bits above a narrow register carry rubbish and must be dropped.
            junk      = CFG_DATA_W'($urandom);
            cfg_we    <= 1'b1;
            cfg_addr  <= reg_index[i];
            cfg_wdata <= reg_value[i] | CFG_DATA_W'(junk << reg_width[i]);
            @(posedge clk);
        end
        cfg_we    <= 1'b0;
        sched_cfg = settings;
    endtask

    function automatic logic [DIV_W-1:0] pick_divisor();
        case ($urandom_range(0, 9))
            0:       return 8'd255;
            1:       return DIV_W'($urandom_range(1, 255));
            default: return DIV_W'($urandom_range(1, 5));
        endcase
    endfunction

    // Mostly short lines and low vblank lines, so that edges and frame ends come often.
    function automatic cfg_t random_settings();
        cfg_t c;
        c.video_mode = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 3) == 0)
            c.line_length = LINE_W'($urandom_range(1, 4095));
        else
            c.line_length = LINE_W'($urandom_range(1, 12));
        c.line_step_tick  = LINE_W'($urandom_range(0, c.line_length));
        c.frame_edge_tick = LINE_W'($urandom_range(0, c.line_length));
        c.video_divisor   = pick_divisor();
        c.cpu_divisor     = pick_divisor();
        if ($urandom_range(0, 4) == 0)
        begin
            c.vblank_first_line = SCAN_W'($urandom_range(0, 511));
            c.vblank_last_line  = SCAN_W'($urandom_range(0, 511));
        end
        else
        begin
            c.vblank_first_line = SCAN_W'($urandom_range(0, 4));
            c.vblank_last_line  = SCAN_W'($urandom_range(0, 4));
        end
        return c;
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Every request kind under the reset settings, with the instruction length extremes.
    task automatic test_reset_defaults();
        send_gap_max    = 15;
        ready_stall_max = 15;
        send_request(REQ_TICK, 8'h00);
        send_request(REQ_CPU_DONE, 8'h00);
        send_request(REQ_TICK, 8'hFF);
        send_request(REQ_CPU_DONE, 8'hFF);
        send_request(REQ_VIDEO_DONE, 8'h5A);
        send_request(REQ_UNUSED, 8'hFF);
        send_request(REQ_TICK, 8'hA5);
    endtask

    // A two-tick line: a frame end leaves vblank, and the first vblank line raises it again.
    task automatic test_frame_edges();
        cfg_t c;
        c                   = sched_cfg;
        c.line_length       = 12'd2;
        c.line_step_tick    = 12'd1;
        c.frame_edge_tick   = 12'd1;
        c.vblank_first_line = 9'd1;
        c.vblank_last_line  = 9'd2;
        c.cpu_divisor       = 8'd2;
        program_config(c);
        send_ticks(8);
    endtask

    // First and last vblank lines equal: rise and frame end on the same tick.
    task automatic test_both_edges();
        cfg_t c;
        c                   = sched_cfg;
        c.vblank_first_line = 9'd1;
        c.vblank_last_line  = 9'd1;
        program_config(c);
        send_ticks(2);
    endtask

    // Zero divisor gives a slot every tick; a divisor cut below the phase wraps it to zero.
    task automatic test_divisors();
        cfg_t c;
        c               = sched_cfg;
        c.video_divisor = 8'd0;
        c.cpu_divisor   = 8'd200;
        program_config(c);
        send_request(REQ_CPU_DONE, 8'd3);
        send_ticks(2);
        c.video_divisor = 8'd255;
        c.cpu_divisor   = 8'd1;
        program_config(c);
        send_ticks(2);
    endtask

    // Longest line with register extremes, then the line cut below the current tick,
    // then a zero line length.
    task automatic test_line_limits();
        cfg_t c;
        c                   = sched_cfg;
        c.video_mode        = 1'b1;
        c.line_length       = 12'd4095;
        c.line_step_tick    = 12'd4095;
        c.frame_edge_tick   = 12'd0;
        c.cpu_divisor       = 8'd255;
        c.vblank_first_line = 9'd511;
        c.vblank_last_line  = 9'd0;
        program_config(c);
        send_ticks(2);
        c.line_length = 12'd1;
        program_config(c);
        send_ticks(2);
        c.line_length = 12'd0;
        program_config(c);
        send_ticks(1);
    endtask

    // One scanline per tick and no frame edge, so the scanline number wraps past 511.
    task automatic test_scanline_wrap();
        cfg_t c;
        c                 = random_settings();
        c.line_length     = 12'd1;
        c.line_step_tick  = 12'd1;
        c.frame_edge_tick = 12'd0;
        program_config(c);
        send_gap_max    = 0;
        ready_stall_max = 0;
        send_random(280, 95);
        send_gap_max    = 15;
        ready_stall_max = 15;
        send_random(280, 95);
    endtask

    // A long line lets the beam pass the NTSC step point and overflow eight bits.
    task automatic test_long_line_beam();
        cfg_t c;
        c                 = random_settings();
        c.video_mode      = 1'b0;
        c.line_length     = 12'd4095;
        c.line_step_tick  = 12'd4095;
        c.frame_edge_tick = 12'd4095;
        c.cpu_divisor     = 8'd255;
        program_config(c);
        send_random(280, 95);
        c.video_mode = 1'b1;
        program_config(c);
        send_random(10, 90);
    endtask

    // The result side holds off for a long stretch while requests keep coming, so the
    // block fills and drops s_axis_tready until the hold-off ends.
    task automatic test_backpressure();
        program_config(random_settings());
        send_gap_max     = 0;
        ready_stall_max  = 0;
        hold_off_request = 80;
        send_random(40, 80);
    endtask

    // Random settings per phase, alternating between heavy idling and none at all.
    task automatic test_random_settings();
        int phase;
        for (phase = 0; phase < 4; phase++)
        begin
            program_config(random_settings());
            send_gap_max    = (phase % 2 == 0) ? 15 : 0;
            ready_stall_max = (phase % 2 == 0) ? 15 : 0;
            send_random(60, 70);
        end
    endtask

    initial
    begin
        reset_prediction();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_frame_edges();
        test_both_edges();
        test_divisors();
        test_line_limits();
        test_scanline_wrap();
        test_long_line_beam();
        test_backpressure();
        test_random_settings();

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("PASS video_master_clock_scheduler_top");
        else
            $display("FAIL video_master_clock_scheduler_top");
        $finish;
    end

endmodule
